### hdl/lfo_pkg.sv
// ----------------------------------------------------------------------------
// lfo_pkg
// Shared types and constants for the low-frequency oscillator.
// ----------------------------------------------------------------------------
package lfo_pkg;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned IDX_W   = 2;

  localparam logic [PHASE_W-1:0] DUTY_RESET = 16'h8000;
  localparam logic [VAL_W-1:0]   HELD_RESET = 8'h80;
  localparam logic [VAL_W-1:0]   VAL_HIGH   = 8'hFF;
  localparam logic [VAL_W-1:0]   VAL_LOW    = 8'h00;
  localparam logic [VAL_W-1:0]   SIGN_FLIP  = 8'h80;

  // Register map
  localparam logic [IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [IDX_W-1:0] REG_WAVE_SEL   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DUTY       = 2'd2;

  typedef enum logic [2:0] {
    WAVE_TRIANGLE    = 3'd0,
    WAVE_SAW         = 3'd1,
    WAVE_SQUARE      = 3'd2,
    WAVE_SAMPLE_HOLD = 3'd3,
    WAVE_NOISE       = 3'd4
  } wave_sel_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    wave_sel_t          wave_sel;
    logic [PHASE_W-1:0] duty;
  } lfo_cfg_t;

endpackage

### hdl/lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Low-frequency oscillator on a 16-bit DDS phase accumulator with triangle,
// saw, square, sample-and-hold and noise outputs.
// ----------------------------------------------------------------------------
//  channel | signals                          | word
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_random_byte | one sample tick + random byte
//  out     | out_valid, out_stall, out_lfo_out  | signed sample, held - 128
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | register write
//          | cfg_data                         |
//
// One word per clock while out_stall is low; each result is registered.
// The phase add, compare and select sit between the input handshake and the
// output register, so the 16-bit add/compare sets the cycle time.
// A skid register holds one word while out_stall is high; in_stall rises
// only when that skid is full. Synchronous active-low reset clears phase,
// edge tracker, registers and both output slots. cfg_ready is always high.
// ----------------------------------------------------------------------------
module lfo_waveform_generator import lfo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // tick input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VAL_W-1:0]         in_random_byte,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_lfo_out,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [PHASE_W-1:0]       cfg_data
);

  lfo_cfg_t         cfg_r;
  logic             in_take;
  logic             out_take;
  logic [VAL_W-1:0] held_nxt;
  logic [VAL_W-1:0] res;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_r;
  logic             skid_valid_r;
  logic [VAL_W-1:0] skid_r;

  assign cfg_ready = 1'b1;

  // Register file; unused waveform codes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step <= '0;
      cfg_r.wave_sel   <= WAVE_TRIANGLE;
      cfg_r.duty       <= DUTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP: cfg_r.phase_step <= cfg_data;
        REG_WAVE_SEL: begin
          if (cfg_data[2:0] <= WAVE_NOISE)
            cfg_r.wave_sel <= wave_sel_t'(cfg_data[2:0]);
        end
        REG_DUTY:       cfg_r.duty <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  lfo_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_take),
    .random_byte (in_random_byte),
    .cfg         (cfg_r),
    .held_nxt    (held_nxt)
  );

  // held - 128 as two's complement is a flip of the MSB
  assign res = held_nxt ^ SIGN_FLIP;

  // Output register with one-word skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_take;
      end
    end else if (in_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r)
        out_r <= skid_r;
      else if (in_take)
        out_r <= res;
    end else if (in_take) begin
      skid_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_lfo_out = out_r;

endmodule

### hdl/lfo_core.sv
// ----------------------------------------------------------------------------
// lfo_core
// Phase accumulator, edge tracker and waveform select; the value for a
// tick is formed combinationally and the state advances when step is high.
// ----------------------------------------------------------------------------
module lfo_core import lfo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [VAL_W-1:0] random_byte,
  input  lfo_cfg_t         cfg,
  output logic [VAL_W-1:0] held_nxt
);

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [VAL_W-1:0]   held_r;
  logic               armed_r;
  logic               armed_nxt;
  logic               top;

  assign phase_nxt = phase_r + cfg.phase_step;
  assign top       = phase_nxt[PHASE_W-1];

  always_comb begin
    held_nxt  = held_r;
    armed_nxt = armed_r;
    unique case (cfg.wave_sel)
      WAVE_TRIANGLE: begin
        held_nxt = top ? ~phase_nxt[PHASE_W-2 -: VAL_W] : phase_nxt[PHASE_W-2 -: VAL_W];
      end
      WAVE_SAW: begin
        held_nxt = phase_nxt[PHASE_W-1 -: VAL_W];
      end
      WAVE_SQUARE: begin
        held_nxt = (phase_nxt > cfg.duty) ? VAL_LOW : VAL_HIGH;
      end
      WAVE_SAMPLE_HOLD: begin
        // latch on rising edge of the phase MSB
        if (top) begin
          if (armed_r) begin
            held_nxt  = random_byte;
            armed_nxt = 1'b0;
          end
        end else begin
          armed_nxt = 1'b1;
        end
      end
      WAVE_NOISE: begin
        held_nxt = random_byte;
      end
      default: begin
        held_nxt = held_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      held_r  <= HELD_RESET;
      armed_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

### hdl/lfo_checker.sv
// ----------------------------------------------------------------------------
// lfo_checker
// Port-level checks on the oscillator's handshakes and latency.
// ----------------------------------------------------------------------------
module lfo_checker import lfo_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_lfo_out
);

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a word offered on a stalled output is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word lost");

  // a stalled output word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_lfo_out))
    else $error("stalled output word changed");

  // input backpressure only when a result is already waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall with empty output");

  // a tick into an empty output shows next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("result missing one cycle after tick");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (.*);

### tb/tb_lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// tb_lfo_waveform_generator
// Self-checking bench for the LFO: drives sample ticks with random bytes,
// reprograms step, waveform and duty between bursts while the block is idle,
// and checks every output word against a cycle-free model of the oscillator.
// ----------------------------------------------------------------------------
module tb_lfo_waveform_generator;
  import lfo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int unsigned      RAND_TICKS   = 1150;
  localparam int unsigned      IDLE_LIMIT   = 2000;
  localparam int unsigned      SHOW_MAX     = 10;

  // --------------------------------------------------------------------------
  // Oscillator model plus queue of expected output words.
  // --------------------------------------------------------------------------
  class lfo_sample_tracker;
    logic [PHASE_W-1:0] step;
    wave_sel_t          wave;
    logic [PHASE_W-1:0] duty;
    logic [PHASE_W-1:0] phase;
    logic [VAL_W-1:0]   held;
    bit                 armed;
    logic [VAL_W-1:0]   expected_samples[$];
    int unsigned        mismatches;

    function new();
      step       = '0;
      wave       = WAVE_TRIANGLE;
      duty       = DUTY_RESET;
      phase      = '0;
      held       = HELD_RESET;
      armed      = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [PHASE_W-1:0] data);
      case (idx)
        REG_PHASE_STEP: step = data;
        REG_WAVE_SEL: begin
          // unused selector codes keep the current waveform
          if (data[2:0] <= WAVE_NOISE) wave = wave_sel_t'(data[2:0]);
        end
        REG_DUTY: duty = data;
        default: ;
      endcase
    endfunction

    function void note_tick(logic [VAL_W-1:0] rnd);
      phase = phase + step;
      case (wave)
        WAVE_TRIANGLE: held = phase[15] ? ~phase[14:7] : phase[14:7];
        WAVE_SAW:      held = phase[15:8];
        WAVE_SQUARE:   held = (phase > duty) ? VAL_LOW : VAL_HIGH;
        WAVE_SAMPLE_HOLD: begin
          if (!phase[15]) armed = 1'b1;
          else if (armed) begin
            held  = rnd;
            armed = 1'b0;
          end
        end
        WAVE_NOISE:    held = rnd;
        default: ;
      endcase
      expected_samples.push_back(held ^ SIGN_FLIP);
    endfunction

    function void check_sample(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("%0t: unexpected output word lfo_out=%0d", $realtime, $signed(got));
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("%0t: lfo_out mismatch: expected %0d (0x%02h) got %0d (0x%02h)",
                   $realtime, $signed(want), want, $signed(got), got);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [VAL_W-1:0]        in_random_byte = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_lfo_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [PHASE_W-1:0]      cfg_data = '0;

  lfo_waveform_generator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_random_byte (in_random_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lfo_out    (out_lfo_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  lfo_sample_tracker tracker = new();
  bit                quiet = 1'b0;   // suppresses idling on both sides
  int unsigned       idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side back-pressure: ~12% of cycles stalled unless in a quiet stretch.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the DUT's own
  // nonblocking updates land. Output is checked before the tick of the same
  // edge is noted; a tick can never produce its word in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_sample(out_lfo_out);
      if (cfg_valid && cfg_ready)  tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)   tracker.note_tick(in_random_byte);
      if ((out_valid && !out_stall) || (cfg_valid && cfg_ready) || (in_valid && !in_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: a long run with no handshake on any channel means a hang.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. All run from a falling edge and return on a falling edge.
  // in_valid stays high after a word so back-to-back ticks never toggle it
  // within one time step.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [VAL_W-1:0] rnd);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_random_byte <= rnd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_tick(VAL_W'($urandom));
  endtask

  // Drop in_valid and wait for every expected word to come out, then let the
  // output side drain; registers are only written after a settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PHASE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [PHASE_W-1:0] pick_wide();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return DUTY_RESET;
      3, 4:    return PHASE_W'($urandom_range(1, 700));  // slow LFO rates
      default: return PHASE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int          burst;
    logic [2:0]  sel;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: zero step, triangle, phase parked at 0.
    send_tick(8'h00);
    send_tick(8'hFF);

    // Triangle through all four quadrants, including the inverted half.
    settle();
    write_reg(REG_PHASE_STEP, 16'h4000);
    send_ticks(4);

    // Saw at the largest step (phase walks backwards by one).
    settle();
    write_reg(REG_WAVE_SEL, PHASE_W'(WAVE_SAW));
    write_reg(REG_PHASE_STEP, 16'hFFFF);
    send_ticks(2);

    // Square at both duty extremes.
    settle();
    write_reg(REG_WAVE_SEL, PHASE_W'(WAVE_SQUARE));
    write_reg(REG_DUTY, 16'hFFFF);
    send_ticks(2);
    settle();
    write_reg(REG_DUTY, 16'h0000);
    send_ticks(2);

    // Sample-and-hold: half-period step gives a rising edge every other tick.
    settle();
    write_reg(REG_WAVE_SEL, PHASE_W'(WAVE_SAMPLE_HOLD));
    write_reg(REG_PHASE_STEP, 16'h8000);
    send_tick(8'hAA);
    send_tick(8'h55);
    send_tick(8'hFF);
    send_tick(8'h00);

    // Noise, then the unused selector codes, which must leave noise in place.
    settle();
    write_reg(REG_WAVE_SEL, PHASE_W'(WAVE_NOISE));
    send_tick(8'h00);
    send_tick(8'hFF);
    settle();
    for (int code = int'(WAVE_NOISE) + 1; code < 8; code++)
      write_reg(REG_WAVE_SEL, PHASE_W'(code));
    send_tick(8'h81);

    // Upper data bits are ignored by the selector; unmapped index is a no-op.
    settle();
    write_reg(REG_WAVE_SEL, {13'h1FFF, WAVE_SAW});
    write_reg(REG_UNMAPPED, 16'h1234);
    send_ticks(2);

    // Random bursts; before each, step, waveform and duty may be rewritten at random.
    sent = 0;
    while (sent < RAND_TICKS) begin
      settle();
      quiet = (sent >= 300 && sent < 550);
      if ($urandom_range(9) < 7) write_reg(REG_PHASE_STEP, pick_wide());
      if ($urandom_range(9) < 7) begin
        sel = 3'($urandom_range(7));
        write_reg(REG_WAVE_SEL, {13'($urandom), sel});
      end
      if ($urandom_range(9) < 6) write_reg(REG_DUTY, pick_wide());
      if ($urandom_range(9) == 0) write_reg(REG_UNMAPPED, PHASE_W'($urandom));
      burst = $urandom_range(8, 60);
      send_ticks(burst);
      sent += burst;
    end
    quiet = 1'b0;

    settle();
    repeat (4) @(negedge clk);   // catch any stray trailing word
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
